@@ rtl/core/lcpe_pkg.sv @@
// ----------------------------------------------------------------------------
// lcpe_pkg
// Shared types and constants of the liquid crystal pair energy core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcpe_pkg;

    localparam int SPECIES_COUNT   = 2;
    localparam int MAX_NEIGHBORS   = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int VEC_W     = 16;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = 32;
    localparam int ENERGY_W  = 32;
    localparam int CNT_W     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int SLOT_N    = 3;

    localparam logic signed [COEF_W-1:0] GAMMA_RESET = 16'sd0;
    localparam logic signed [COEF_W-1:0] EPS_RESET   = 16'sd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAMMA_11,
        REG_GAMMA_12,
        REG_GAMMA_22,
        REG_EPS_11,
        REG_EPS_12,
        REG_EPS_22
    } reg_index_t;

    typedef enum logic [1:0] {
        SLOT_11,
        SLOT_12,
        SLOT_22
    } slot_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] center_x;
        logic signed [VEC_W-1:0] center_y;
        logic signed [VEC_W-1:0] center_z;
        logic                    center_kind;
        logic signed [VEC_W-1:0] nbr_x;
        logic signed [VEC_W-1:0] nbr_y;
        logic signed [VEC_W-1:0] nbr_z;
        logic                    nbr_kind;
        logic                    final_nbr;
    } in_item_t;

    typedef struct packed {
        logic signed [ENERGY_W-1:0] site_energy;
        logic [CNT_W-1:0]           nbr_count;
    } out_item_t;

    typedef struct packed {
        logic [SLOT_N-1:0][COEF_W-1:0] gamma;
        logic [SLOT_N-1:0][COEF_W-1:0] eps;
    } coef_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] prod_x;
        logic signed [PROD_W-1:0] prod_y;
        logic signed [PROD_W-1:0] prod_z;
        logic signed [COEF_W-1:0] gamma;
        logic signed [COEF_W-1:0] eps;
        logic                     final_nbr;
    } work_t;

endpackage

@@ rtl/core/lcpe_cfg.sv @@
// ----------------------------------------------------------------------------
// lcpe_cfg
// Coupling register file: three gamma and three eps words, Q8.8.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcpe_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lcpe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lcpe_pkg::COEF_W-1:0]    cfg_data,
    output lcpe_pkg::coef_t                coef
);
    import lcpe_pkg::*;

    logic [SLOT_N-1:0][COEF_W-1:0] gamma_reg;
    logic [SLOT_N-1:0][COEF_W-1:0] eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_N; i++)
            begin
                gamma_reg[i] <= GAMMA_RESET;
                eps_reg[i]   <= EPS_RESET;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAMMA_11: gamma_reg[SLOT_11] <= cfg_data;
                REG_GAMMA_12: gamma_reg[SLOT_12] <= cfg_data;
                REG_GAMMA_22: gamma_reg[SLOT_22] <= cfg_data;
                REG_EPS_11:   eps_reg[SLOT_11]   <= cfg_data;
                REG_EPS_12:   eps_reg[SLOT_12]   <= cfg_data;
                REG_EPS_22:   eps_reg[SLOT_22]   <= cfg_data;
                default:      ; // unknown index, write dropped
            endcase
        end
    end

    assign coef.gamma = gamma_reg;
    assign coef.eps   = eps_reg;

endmodule

@@ rtl/core/lcpe_front.sv @@
// ----------------------------------------------------------------------------
// lcpe_front
// Accepts neighbor items, picks the species pair coefficients and forms
// the three component products of the dot product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcpe_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  lcpe_pkg::in_item_t in_item,
    input  lcpe_pkg::coef_t    coef,
    input  logic               q_full,
    output logic               push,
    output lcpe_pkg::work_t    work
);
    import lcpe_pkg::*;

    logic  front_valid_reg;
    logic  front_valid_next;
    work_t work_reg;
    work_t work_next;
    logic  accept;
    logic  kind_a;
    logic  kind_b;
    slot_t slot;

    logic signed [VEC_W-1:0]  cx, cy, cz, nx, ny, nz;
    logic signed [PROD_W-1:0] px, py, pz;

    assign in_stall = front_valid_reg & q_full;
    assign accept   = in_valid & ~in_stall;
    assign push     = front_valid_reg & ~q_full;
    assign work     = work_reg;

    always_comb
    begin
        // species codes clamp to the highest species present
        kind_a = (SPECIES_COUNT > 1) ? in_item.center_kind : 1'b0;
        kind_b = (SPECIES_COUNT > 1) ? in_item.nbr_kind : 1'b0;
        if (!kind_a && !kind_b)
            slot = SLOT_11;
        else if (kind_a != kind_b)
            slot = SLOT_12;
        else
            slot = SLOT_22;

        cx = in_item.center_x;
        cy = in_item.center_y;
        cz = in_item.center_z;
        nx = in_item.nbr_x;
        ny = in_item.nbr_y;
        nz = in_item.nbr_z;
        px = cx * nx;
        py = cy * ny;
        pz = cz * nz;

        work_next.prod_x    = px;
        work_next.prod_y    = py;
        work_next.prod_z    = pz;
        work_next.gamma     = coef.gamma[slot];
        work_next.eps       = coef.eps[slot];
        work_next.final_nbr = in_item.final_nbr;

        if (accept)
            front_valid_next = 1'b1;
        else if (push)
            front_valid_next = 1'b0;
        else
            front_valid_next = front_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else
            front_valid_reg <= front_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            work_reg <= work_next;
    end

endmodule

@@ rtl/core/lcpe_queue.sv @@
// ----------------------------------------------------------------------------
// lcpe_queue
// Small item queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcpe_queue #(
    parameter int DEPTH = lcpe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lcpe_pkg::work_t wdata,
    input  logic            pop,
    output lcpe_pkg::work_t rdata,
    output logic            full,
    output logic            empty
);
    import lcpe_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    work_t         mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push_ok;
    logic          pop_ok;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push & ~full;
    assign pop_ok  = pop & ~empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push_ok)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop_ok)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({push_ok, pop_ok})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

@@ rtl/core/lcpe_back.sv @@
// ----------------------------------------------------------------------------
// lcpe_back
// Pair energy pipeline: dot rounding, P2, eps product in two halves,
// gamma add, then the saturating site accumulator and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcpe_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  lcpe_pkg::work_t     q_data,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output lcpe_pkg::out_item_t out_item
);
    import lcpe_pkg::*;

    localparam int DOT_W  = PROD_W + 2;
    localparam int D14_W  = 19;
    localparam int SQ_W   = 36;
    localparam int P2_W   = SQ_W + 2;
    localparam int LO_W   = 19;
    localparam int HI_W   = P2_W - LO_W;
    localparam int PLO_W  = COEF_W + LO_W + 1;
    localparam int PHI_W  = COEF_W + HI_W;
    localparam int MUL_W  = 54;
    localparam int ET_W   = MUL_W - 29;
    localparam int TERM_W = ET_W + 1;
    localparam int ACC_W  = ENERGY_W + 1;

    localparam logic signed [DOT_W-1:0] DOT_ROUND = DOT_W'(1) << 13;
    localparam logic signed [P2_W-1:0]  P2_OFFSET = P2_W'(1) << 28;
    localparam logic signed [MUL_W-1:0] MUL_ROUND = MUL_W'(1) << 28;
    localparam logic signed [ENERGY_W-1:0] E_MAX  = {1'b0, {(ENERGY_W-1){1'b1}}};
    localparam logic signed [ENERGY_W-1:0] E_MIN  = {1'b1, {(ENERGY_W-1){1'b0}}};

    logic enable;

    // stage valids and the site state
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic signed [ENERGY_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       out_valid_reg, out_valid_next;
    out_item_t                  out_item_reg, out_item_next;

    // stage payloads
    logic signed [D14_W-1:0]  s1_d14_reg, s1_d14_next;
    logic signed [COEF_W-1:0] s1_gamma_reg, s1_eps_reg;
    logic                     s1_final_reg;
    logic [SQ_W-1:0]          s2_sq_reg, s2_sq_next;
    logic signed [COEF_W-1:0] s2_gamma_reg, s2_eps_reg;
    logic                     s2_final_reg;
    logic signed [P2_W-1:0]   s3_p2_reg, s3_p2_next;
    logic signed [COEF_W-1:0] s3_gamma_reg, s3_eps_reg;
    logic                     s3_final_reg;
    logic signed [PLO_W-1:0]  s4_plo_reg, s4_plo_next;
    logic signed [PHI_W-1:0]  s4_phi_reg, s4_phi_next;
    logic signed [COEF_W-1:0] s4_gamma_reg;
    logic                     s4_final_reg;
    logic signed [TERM_W-1:0] s5_term_reg, s5_term_next;
    logic                     s5_final_reg;

    logic signed [DOT_W-1:0]   dot_sum;
    logic signed [SQ_W:0]      sq_full;
    logic signed [LO_W:0]      p2_lo;
    logic signed [HI_W-1:0]    p2_hi;
    logic signed [MUL_W-1:0]   mul_sum;
    logic signed [ET_W-1:0]    eps_term;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ENERGY_W-1:0] acc_sat;
    logic [CNT_W-1:0]          count_inc;

    // the whole back advances unless a result waits stalled
    assign enable    = ~(out_valid_reg & out_stall);
    assign pop       = enable & ~q_empty;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        dot_sum     = DOT_W'(q_data.prod_x) + DOT_W'(q_data.prod_y)
                    + DOT_W'(q_data.prod_z) + DOT_ROUND;
        s1_d14_next = dot_sum[D14_W+13:14];

        sq_full     = s1_d14_reg * s1_d14_reg;
        s2_sq_next  = sq_full[SQ_W-1:0];

        // twice P2 at scale 2^28
        s3_p2_next  = P2_W'(s2_sq_reg) + P2_W'({s2_sq_reg, 1'b0}) - P2_OFFSET;

        p2_lo       = {1'b0, s3_p2_reg[LO_W-1:0]};
        p2_hi       = s3_p2_reg[P2_W-1:LO_W];
        s4_plo_next = s3_eps_reg * p2_lo;
        s4_phi_next = s3_eps_reg * p2_hi;

        mul_sum      = (MUL_W'(s4_phi_reg) <<< LO_W) + MUL_W'(s4_plo_reg) + MUL_ROUND;
        eps_term     = mul_sum[MUL_W-1:29];
        s5_term_next = TERM_W'(s4_gamma_reg) + TERM_W'(eps_term);

        acc = ACC_W'(sum_reg) + ACC_W'(s5_term_reg);
        if (acc[ACC_W-1] != acc[ACC_W-2])
            acc_sat = acc[ACC_W-1] ? E_MIN : E_MAX;
        else
            acc_sat = acc[ENERGY_W-1:0];

        count_inc = (count_reg < CNT_W'(MAX_NEIGHBORS)) ? count_reg + 1'b1 : count_reg;

        out_item_next.site_energy = (acc_sat == E_MIN) ? E_MAX : -acc_sat;
        out_item_next.nbr_count   = count_inc;

        sum_next       = sum_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (enable)
        begin
            out_valid_next = s5_valid_reg & s5_final_reg;
            if (s5_valid_reg)
            begin
                if (s5_final_reg)
                begin
                    sum_next   = '0;
                    count_next = '0;
                end
                else
                begin
                    sum_next   = acc_sat;
                    count_next = count_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            sum_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (enable)
            begin
                s1_valid_reg <= ~q_empty;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                s4_valid_reg <= s3_valid_reg;
                s5_valid_reg <= s4_valid_reg;
            end
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            s1_d14_reg   <= s1_d14_next;
            s1_gamma_reg <= q_data.gamma;
            s1_eps_reg   <= q_data.eps;
            s1_final_reg <= q_data.final_nbr;
            s2_sq_reg    <= s2_sq_next;
            s2_gamma_reg <= s1_gamma_reg;
            s2_eps_reg   <= s1_eps_reg;
            s2_final_reg <= s1_final_reg;
            s3_p2_reg    <= s3_p2_next;
            s3_gamma_reg <= s2_gamma_reg;
            s3_eps_reg   <= s2_eps_reg;
            s3_final_reg <= s2_final_reg;
            s4_plo_reg   <= s4_plo_next;
            s4_phi_reg   <= s4_phi_next;
            s4_gamma_reg <= s3_gamma_reg;
            s4_final_reg <= s3_final_reg;
            s5_term_reg  <= s5_term_next;
            s5_final_reg <= s4_final_reg;
            if (s5_valid_reg & s5_final_reg)
                out_item_reg <= out_item_next;
        end
    end

endmodule

@@ rtl/core/liquid_crystal_pair_energy_core.sv @@
// ----------------------------------------------------------------------------
// liquid_crystal_pair_energy_core
// Items pass the front register, queue, stages s1 to s5 and the result register.
// One item per cycle while the queue has room; the queue decouples front and back.
// A stalled result holds the back pipeline; the front keeps filling the queue.
// Reset clears the site sum, the count, the queue and sets gamma to 0, eps to 1.0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module liquid_crystal_pair_energy_core #(
    parameter int QUEUE_DEPTH = lcpe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  lcpe_pkg::in_item_t             in_item,
    output logic                           out_valid,
    input  logic                           out_stall,
    output lcpe_pkg::out_item_t            out_item,
    input  logic                           cfg_we,
    input  logic [lcpe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lcpe_pkg::COEF_W-1:0]    cfg_data
);
    import lcpe_pkg::*;

    coef_t coef;
    work_t front_work;
    work_t q_data;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;

    lcpe_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    lcpe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .coef     (coef),
        .q_full   (q_full),
        .push     (push),
        .work     (front_work)
    );

    lcpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_work),
        .pop   (pop),
        .rdata (q_data),
        .full  (q_full),
        .empty (q_empty)
    );

    lcpe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

@@ rtl/core/lcpe_checker.sv @@
// ----------------------------------------------------------------------------
// lcpe_checker
// Port level checks on the result channel of the pair energy core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcpe_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input lcpe_pkg::out_item_t out_item
);
    import lcpe_pkg::*;

    localparam logic signed [ENERGY_W-1:0] E_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed or dropped");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.nbr_count != '0)
                      && (out_item.nbr_count <= CNT_W'(MAX_NEIGHBORS)))
        else $error("neighbor count out of range");

    // negation of the most negative sum must saturate
    a_neg_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.site_energy != E_MIN)
        else $error("site energy negation overflowed");

endmodule

bind liquid_crystal_pair_energy_core lcpe_checker u_lcpe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

@@ tb/tb_liquid_crystal_pair_energy_core.sv @@
// ----------------------------------------------------------------------------
// tb_liquid_crystal_pair_energy_core
// Self-checking bench for the site energy core. Neighbor items are pushed
// through the valid/stall port from a directed table, then as random sites,
// under several coefficient sets and idle patterns. An in-bench predictor
// accumulates each site and queues the expected energy and neighbor count.
// Every result is compared field by field against that queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_liquid_crystal_pair_energy_core;

    import lcpe_pkg::*;

    localparam int  LIMIT_CYCLES     = 200000;
    localparam int  SETTLE_CYCLES    = 16;
    localparam int  RANDOM_PER_PHASE = 60;
    localparam int  SAT_SITE_LEN     = 325;
    localparam int  UNMAPPED_REG_LO  = REG_EPS_22 + 1;
    localparam longint SUM_MAX       = 64'sd2147483647;
    localparam longint SUM_MIN       = -SUM_MAX - 1;

    typedef enum int {
        COEF_KEEP,
        COEF_SET_A,
        COEF_SPARE
    } coef_step_t;

    typedef struct {
        coef_step_t coef_step;
        in_item_t   item;
        bit         typed;
        out_item_t  want;
    } dir_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_item_t             in_item   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_item;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0]    cfg_data  = '0;

    // bench copy of the coefficient table and the site accumulator
    logic signed [COEF_W-1:0] gamma_cfg [SLOT_N];
    logic signed [COEF_W-1:0] eps_cfg [SLOT_N];
    longint                   site_sum;
    int                       site_count;

    out_item_t pending_sites [$];
    dir_row_t  dir_rows [$];
    int        send_idle_pct = 28;
    int        recv_idle_pct = 52;
    int        bad_fields    = 0;
    int        cycle_count;

    liquid_crystal_pair_energy_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // adds one neighbor to the site sum; returns 1 with the site result on a final item
    function automatic bit accumulate_pair(input in_item_t it, output out_item_t res);
        longint dot28;
        longint d14;
        longint p2x2;
        longint term;
        longint s;
        slot_t  slot;
        dot28 = longint'($signed(it.center_x)) * longint'($signed(it.nbr_x))
              + longint'($signed(it.center_y)) * longint'($signed(it.nbr_y))
              + longint'($signed(it.center_z)) * longint'($signed(it.nbr_z));
        d14  = (dot28 + 64'sd8192) >>> 14;
        p2x2 = 64'sd3 * d14 * d14 - (64'sd1 <<< 28);
        if (it.center_kind != it.nbr_kind)
            slot = SLOT_12;
        else if (it.center_kind)
            slot = SLOT_22;
        else
            slot = SLOT_11;
        term = longint'(gamma_cfg[slot])
             + ((longint'(eps_cfg[slot]) * p2x2 + (64'sd1 <<< 28)) >>> 29);
        s = site_sum + term;
        if (s > SUM_MAX)
            s = SUM_MAX;
        if (s < SUM_MIN)
            s = SUM_MIN;
        site_sum = s;
        if (site_count < MAX_NEIGHBORS)
            site_count++;
        res = '0;
        if (!it.final_nbr)
            return 1'b0;
        s = -site_sum;
        if (s > SUM_MAX)
            s = SUM_MAX;
        res.site_energy = s[ENERGY_W-1:0];
        res.nbr_count   = site_count[CNT_W-1:0];
        site_sum   = 0;
        site_count = 0;
        return 1'b1;
    endfunction

    function automatic dir_row_t nbr_row(coef_step_t step, int cx, int cy, int cz, bit ck,
                                         int nx, int ny, int nz, bit nk, bit fin,
                                         bit typed = 1'b0, int energy = 0, int cnt = 0);
        dir_row_t r;
        r.coef_step        = step;
        r.item.center_x    = 16'(cx);
        r.item.center_y    = 16'(cy);
        r.item.center_z    = 16'(cz);
        r.item.center_kind = ck;
        r.item.nbr_x       = 16'(nx);
        r.item.nbr_y       = 16'(ny);
        r.item.nbr_z       = 16'(nz);
        r.item.nbr_kind    = nk;
        r.item.final_nbr   = fin;
        r.typed            = typed;
        r.want.site_energy = 32'(energy);
        r.want.nbr_count   = 7'(cnt);
        return r;
    endfunction

    function automatic logic [VEC_W-1:0] rand_comp();
        logic [VEC_W-1:0] v;
        case ($urandom_range(7))
            0:
            begin
                case ($urandom_range(4))
                    0: v = 16'h8000;
                    1: v = 16'h7fff;
                    2: v = 16'(-16384);
                    3: v = 16'd16384;
                    default: v = '0;
                endcase
            end
            1: v = 16'($urandom);
            default: v = 16'($urandom_range(32768) - 16384);
        endcase
        return v;
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef();
        logic [COEF_W-1:0] c;
        case ($urandom_range(5))
            0: c = 16'h8000;
            1: c = 16'h7fff;
            2: c = '0;
            3: c = 16'd256;
            4: c = 16'($urandom);
            default: c = 16'($urandom_range(1024) - 512);
        endcase
        return c;
    endfunction

    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx <= REG_GAMMA_22)
            gamma_cfg[idx] = val;
        else if (idx <= REG_EPS_22)
            eps_cfg[idx - REG_EPS_11] = val;
        @(posedge clk);
    endtask

    task automatic program_coefs(input logic [5:0][COEF_W-1:0] vals);
        for (int r = REG_GAMMA_11; r <= REG_EPS_22; r++)
            write_coef(r[CFG_IDX_W-1:0], vals[r]);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // indexes past the last register must leave the table alone
    task automatic poke_unmapped_regs();
        for (int r = UNMAPPED_REG_LO; r < 2 ** CFG_IDX_W; r++)
            write_coef(r[CFG_IDX_W-1:0], 16'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every pending site result is back and the pipe has drained
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_sites.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_nbr(input in_item_t it, input bit typed, input out_item_t want);
        out_item_t got;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        if (accumulate_pair(it, got))
            pending_sites.push_back(typed ? want : got);
    endtask

    task automatic run_sites(input int n_items);
        in_item_t it;
        int       left;
        int       site_len;
        left = n_items;
        while (left > 0)
        begin
            site_len = ($urandom_range(9) == 0) ? $urandom_range(72, 60) : $urandom_range(12, 1);
            if (site_len > left)
                site_len = left;
            it.center_x    = rand_comp();
            it.center_y    = rand_comp();
            it.center_z    = rand_comp();
            it.center_kind = $urandom_range(1);
            for (int k = 0; k < site_len; k++)
            begin
                // now and then the center drifts mid-site
                if ($urandom_range(19) == 0)
                begin
                    it.center_x    = rand_comp();
                    it.center_kind = $urandom_range(1);
                end
                it.nbr_x     = rand_comp();
                it.nbr_y     = rand_comp();
                it.nbr_z     = rand_comp();
                it.nbr_kind  = $urandom_range(1);
                it.final_nbr = (k == site_len - 1);
                send_nbr(it, 1'b0, '0);
            end
            left -= site_len;
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct);
        logic [5:0][COEF_W-1:0] vals;
        settle();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int r = REG_GAMMA_11; r <= REG_EPS_22; r++)
            vals[r] = pick_coef();
        program_coefs(vals);
        run_sites(RANDOM_PER_PHASE);
    endtask

    // one long site of aligned extreme vectors drives the sum into its clamp
    task automatic drive_saturating_site(input logic [COEF_W-1:0] coef);
        in_item_t it;
        settle();
        program_coefs({6{coef}});
        for (int k = 0; k < SAT_SITE_LEN; k++)
        begin
            it.center_x    = $urandom_range(1) ? 16'h8000 : 16'h7fff;
            it.center_y    = $urandom_range(1) ? 16'h8000 : 16'h7fff;
            it.center_z    = $urandom_range(1) ? 16'h8000 : 16'h7fff;
            it.nbr_x       = it.center_x;
            it.nbr_y       = it.center_y;
            it.nbr_z       = it.center_z;
            it.center_kind = $urandom_range(1);
            it.nbr_kind    = $urandom_range(1);
            it.final_nbr   = (k == SAT_SITE_LEN - 1);
            send_nbr(it, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (pending_sites.size() == 0)
            begin
                $error("unexpected site result: energy %0d count %0d",
                       $signed(out_item.site_energy), out_item.nbr_count);
                bad_fields++;
            end
            else
            begin
                want = pending_sites.pop_front();
                if (out_item.site_energy !== want.site_energy)
                begin
                    $error("site_energy: expected %0d, got %0d",
                           $signed(want.site_energy), $signed(out_item.site_energy));
                    bad_fields++;
                end
                if (out_item.nbr_count !== want.nbr_count)
                begin
                    $error("nbr_count: expected %0d, got %0d",
                           want.nbr_count, out_item.nbr_count);
                    bad_fields++;
                end
            end
        end
    end

    initial
    begin : watchdog
        for (cycle_count = 0; cycle_count < LIMIT_CYCLES; cycle_count++)
            @(posedge clk);
        $display("** liquid_crystal_pair_energy_core: FAILED **");
        $finish;
    end

    initial
    begin : main_seq
        logic [5:0][COEF_W-1:0] set_a;
        for (int s = 0; s < SLOT_N; s++)
        begin
            gamma_cfg[s] = GAMMA_RESET;
            eps_cfg[s]   = EPS_RESET;
        end
        site_sum   = 0;
        site_count = 0;

        set_a[REG_GAMMA_11] = 16'h8000;
        set_a[REG_GAMMA_12] = 16'h7fff;
        set_a[REG_GAMMA_22] = 16'd384;
        set_a[REG_EPS_11]   = 16'h7fff;
        set_a[REG_EPS_12]   = 16'h8000;
        set_a[REG_EPS_22]   = 16'(-512);

        // reset coefficients: gamma 0, eps 1.0, so aligned gives -1.0 and square gives +0.5
        dir_rows.push_back(nbr_row(COEF_KEEP, 16384, 0, 0, 0, 16384, 0, 0, 0, 1, 1, -256, 1));
        dir_rows.push_back(nbr_row(COEF_KEEP, 16384, 0, 0, 0, -16384, 0, 0, 0, 1, 1, -256, 1));
        dir_rows.push_back(nbr_row(COEF_KEEP, 16384, 0, 0, 1, 0, 16384, 0, 1, 1, 1, 128, 1));
        dir_rows.push_back(nbr_row(COEF_KEEP, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 128, 1));
        // extreme coefficients, off-sphere vectors, every species pairing
        dir_rows.push_back(nbr_row(COEF_SET_A, -32768, -32768, -32768, 0,
                                   -32768, -32768, -32768, 0, 1));
        dir_rows.push_back(nbr_row(COEF_KEEP, 32767, 32767, 32767, 1,
                                   32767, 32767, 32767, 1, 1));
        dir_rows.push_back(nbr_row(COEF_KEEP, 32767, 32767, 32767, 0,
                                   -32768, -32768, -32768, 1, 1));
        dir_rows.push_back(nbr_row(COEF_KEEP, 11585, 11585, 0, 1, 16384, 0, 0, 0, 1));
        // one multi-neighbor site
        dir_rows.push_back(nbr_row(COEF_KEEP, 0, 0, 16384, 0, 0, 0, 16384, 0, 0));
        dir_rows.push_back(nbr_row(COEF_KEEP, 0, 0, 16384, 0, 9459, 9459, 9459, 1, 0));
        dir_rows.push_back(nbr_row(COEF_KEEP, 0, 0, 16384, 1, 0, 16384, 0, 0, 0));
        dir_rows.push_back(nbr_row(COEF_KEEP, 0, 0, 16384, 1, 0, 0, -16384, 1, 0));
        dir_rows.push_back(nbr_row(COEF_KEEP, 0, 0, 16384, 1, -8192, 8192, 8192, 1, 1));
        dir_rows.push_back(nbr_row(COEF_KEEP, 16384, 16384, 16384, 0, -16384, 16384, 0, 0, 1));
        // dot rounding right at the half step, both signs
        dir_rows.push_back(nbr_row(COEF_KEEP, 1, 0, 0, 0, 8192, 0, 0, 0, 1));
        dir_rows.push_back(nbr_row(COEF_KEEP, -1, 0, 0, 1, 8192, 0, 0, 1, 1));
        // writes to unmapped indexes, then the same items again
        dir_rows.push_back(nbr_row(COEF_SPARE, -32768, -32768, -32768, 0,
                                   -32768, -32768, -32768, 0, 1));
        dir_rows.push_back(nbr_row(COEF_KEEP, 32767, 32767, 32767, 0,
                                   -32768, -32768, -32768, 1, 1));
        dir_rows.push_back(nbr_row(COEF_KEEP, 0, 0, 16384, 1, -8192, 8192, 8192, 1, 1));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].coef_step != COEF_KEEP)
            begin
                settle();
                if (dir_rows[i].coef_step == COEF_SET_A)
                    program_coefs(set_a);
                else
                    poke_unmapped_regs();
            end
            send_nbr(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        end

        run_phase(28, 52);
        run_phase(52, 28);
        run_phase(0, 0);
        drive_saturating_site(16'h7fff);
        drive_saturating_site(16'h8000);
        settle();

        if (bad_fields == 0)
            $display("** liquid_crystal_pair_energy_core: PASSED **");
        else
            $display("** liquid_crystal_pair_energy_core: FAILED **");
        $finish;
    end

endmodule
